// ----- src/sjfq_pkg.sv -----
package sjfq_pkg;

  // Number of cells in the sorted row.
  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Slave-side packing: tdata = {burst_time, job_id}, tuser = kind.
  localparam int unsigned IN_DATA_W  = ID_W + KEY_W;
  // Master-side packing: tdata = {pad, occupancy, popped_burst, popped_id},
  // tuser = {insert_rejected, popped_valid}.
  localparam int unsigned OUT_FIELD_W = ID_W + KEY_W + OCC_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W  = 2;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_e;

  // Broadcast to every cell in the cycle a request is taken.
  typedef struct packed {
    logic             insert;
    logic             pop;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } cell_ctrl_t;

endpackage

// ----- src/sjfq_cell.sv -----
module sjfq_cell (
  input  logic                     clk_i,
  input  sjfq_pkg::cell_ctrl_t     ctrl_i,
  input  logic                     occupied_i,
  input  logic                     left_after_i,
  input  logic [sjfq_pkg::KEY_W-1:0] left_key_i,
  input  logic [sjfq_pkg::ID_W-1:0]  left_id_i,
  input  logic [sjfq_pkg::KEY_W-1:0] right_key_i,
  input  logic [sjfq_pkg::ID_W-1:0]  right_id_i,
  output logic                     after_o,
  output logic [sjfq_pkg::KEY_W-1:0] key_o,
  output logic [sjfq_pkg::ID_W-1:0]  id_o
);
  import sjfq_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [ID_W-1:0]  id_q, id_d;

  // The new job goes behind this cell when this cell holds a key <= its own.
  assign after_o = occupied_i && (key_q <= ctrl_i.key);

  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    if (ctrl_i.insert && !after_o) begin
      if (left_after_i) begin
        key_d = ctrl_i.key;
        id_d  = ctrl_i.id;
      end else begin
        key_d = left_key_i;
        id_d  = left_id_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
      id_d  = right_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign key_o = key_q;
  assign id_o  = id_q;

endmodule

// ----- src/shortest_job_first_queue_core.sv -----
// Shortest-job-first ready queue. Each request on the slave stream is either
// an insert (tuser = 0) carrying a job id and burst time, or a pop (tuser = 1)
// that returns the job with the shortest burst; every request yields exactly
// one result on the master stream. Jobs sit in a row of QUEUE_DEPTH cells kept
// sorted by ascending burst time, equal bursts in arrival order. On an insert
// every cell compares its key with the new one in parallel and the cells at and
// behind the insertion point shift one place toward the tail; on a pop every
// cell takes its right neighbor's entry. One request is taken per clock cycle:
// the cell row updates all cells at once and a result register decouples the
// two streams, so a new request is accepted whenever that register is empty or
// being drained. A pop on an empty queue reports popped_valid = 0 with zero
// fields; an insert into a full queue drops the job and flags insert_rejected.
// occupancy gives the job count after the request, in 5 bits.
module shortest_job_first_queue_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sjfq_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // job_id, burst_time
  input  logic                              s_axis_tuser,  // kind
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sjfq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // popped_id, popped_burst,
                                                           // occupancy, zero pad
  output logic [sjfq_pkg::OUT_USER_W-1:0]   m_axis_tuser   // popped_valid,
                                                           // insert_rejected
);
  import sjfq_pkg::*;

  // Unpack the request.
  logic [ID_W-1:0]  in_id;
  logic [KEY_W-1:0] in_key;
  kind_e            in_kind;

  assign in_id   = s_axis_tdata[ID_W-1:0];
  assign in_key  = s_axis_tdata[ID_W+KEY_W-1:ID_W];
  assign in_kind = kind_e'(s_axis_tuser);

  // Job count.
  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty;

  assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  // Take a request when the result register is free or draining this cycle.
  logic out_valid_q;
  logic accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cell_ctrl_t ctrl;

  always_comb begin
    ctrl.insert = accept && (in_kind == KIND_INSERT) && !full;
    ctrl.pop    = accept && (in_kind == KIND_POP) && !empty;
    ctrl.key    = in_key;
    ctrl.id     = in_id;
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Cell row: index 0 is the head (shortest burst).
  logic [KEY_W-1:0]     cell_key   [QUEUE_DEPTH];
  logic [ID_W-1:0]      cell_id    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_after;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic             occupied;
    logic             left_after;
    logic [KEY_W-1:0] left_key, right_key;
    logic [ID_W-1:0]  left_id, right_id;

    // Slots below the count hold jobs.
    assign occupied = (CNT_W'(g) < count_q);

    if (g == 0) begin : g_head
      // Nothing ahead of the head: a new job that does not go behind it lands here.
      assign left_after = 1'b1;
      assign left_key   = '0;
      assign left_id    = '0;
    end else begin : g_body
      assign left_after = cell_after[g-1];
      assign left_key   = cell_key[g-1];
      assign left_id    = cell_id[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      // Tail slot becomes free on a pop; hold its stale contents.
      assign right_key = cell_key[g];
      assign right_id  = cell_id[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
      assign right_id  = cell_id[g+1];
    end

    sjfq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied),
      .left_after_i (left_after),
      .left_key_i   (left_key),
      .left_id_i    (left_id),
      .right_key_i  (right_key),
      .right_id_i   (right_id),
      .after_o      (cell_after[g]),
      .key_o        (cell_key[g]),
      .id_o         (cell_id[g])
    );
  end

  // Result fields for the request taken this cycle.
  logic             res_valid_d, res_rej_d;
  logic [ID_W-1:0]  res_id_d;
  logic [KEY_W-1:0] res_key_d;
  logic [OCC_W-1:0] res_occ_d;

  always_comb begin
    res_valid_d = ctrl.pop;
    res_rej_d   = accept && (in_kind == KIND_INSERT) && full;
    res_id_d    = ctrl.pop ? cell_id[0]  : '0;
    res_key_d   = ctrl.pop ? cell_key[0] : '0;
    res_occ_d   = OCC_W'(count_d);
  end

  // Result register.
  logic             res_valid_q, res_rej_q;
  logic [ID_W-1:0]  res_id_q;
  logic [KEY_W-1:0] res_key_q;
  logic [OCC_W-1:0] res_occ_q;
  logic             out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_valid_q <= res_valid_d;
      res_rej_q   <= res_rej_d;
      res_id_q    <= res_id_d;
      res_key_q   <= res_key_d;
      res_occ_q   <= res_occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({res_occ_q, res_key_q, res_id_q});
  assign m_axis_tuser  = {res_rej_q, res_valid_q};

endmodule

// ----- src/sjfq_checker.sv -----
module sjfq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sjfq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [sjfq_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import sjfq_pkg::*;

  logic             popped_valid, insert_rejected;
  logic [ID_W-1:0]  popped_id;
  logic [KEY_W-1:0] popped_burst;
  logic [OCC_W-1:0] occupancy;

  assign popped_valid    = m_axis_tuser[0];
  assign insert_rejected = m_axis_tuser[1];
  assign popped_id       = m_axis_tdata[ID_W-1:0];
  assign popped_burst    = m_axis_tdata[ID_W+KEY_W-1:ID_W];
  assign occupancy       = m_axis_tdata[ID_W+KEY_W+OCC_W-1:ID_W+KEY_W];

  // A stalled result stays valid with its tuser flags unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("result dropped or changed while stalled");

  // A result never both pops and rejects.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(popped_valid && insert_rejected))
    else $error("pop and reject flagged together");

  // Without a popped job the job fields read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !popped_valid |-> popped_id == '0 && popped_burst == '0)
    else $error("nonzero job fields without a pop");

  // A rejected insert only happens on a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && insert_rejected |-> occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("insert rejected below full");

  // Requests are taken only while the result side is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken with result stalled");

endmodule

bind shortest_job_first_queue_core sjfq_checker u_sjfq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/shortest_job_first_queue_core_test.sv -----
`timescale 1ns / 100ps

module shortest_job_first_queue_core_test;
  import sjfq_pkg::*;

  localparam int unsigned RANDOM_JOBS = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   job_id;
    logic [KEY_W-1:0]  burst;
  } job_req_t;

  typedef struct packed {
    logic              popped_valid;
    logic [ID_W-1:0]   popped_id;
    logic [KEY_W-1:0]  popped_burst;
    logic              insert_rejected;
    logic [OCC_W-1:0]  occupancy;
  } sjf_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // job_id, burst_time
  logic                   s_axis_tuser = 1'b0; // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;        // popped_id, popped_burst, occupancy, pad
  logic [OUT_USER_W-1:0]  m_axis_tuser;        // popped_valid, insert_rejected

  shortest_job_first_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  job_req_t          job_requests[$];
  sjf_result_t       due_results[$];
  logic [KEY_W-1:0]  ready_keys[$];
  logic [ID_W-1:0]   ready_ids[$];
  job_req_t          on_bus;
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_pause = 0;
  int unsigned       recv_stall = 0;
  sjf_result_t       got;
  sjf_result_t       want;

  // Shadow of the sorted row: apply one request and return its result.
  function automatic sjf_result_t predict_sjf_result(job_req_t req);
    sjf_result_t r;
    int unsigned pos;
    r = '0;
    if (req.kind == KIND_INSERT) begin
      if (ready_keys.size() >= QUEUE_DEPTH) begin
        r.insert_rejected = 1'b1;
      end else begin
        // Equal bursts keep arrival order: go behind every key <= the new one.
        pos = 0;
        while (pos < ready_keys.size() && ready_keys[pos] <= req.burst) pos++;
        ready_keys.insert(pos, req.burst);
        ready_ids.insert(pos, req.job_id);
      end
    end else if (ready_keys.size() > 0) begin
      r.popped_valid = 1'b1;
      r.popped_id    = ready_ids.pop_front();
      r.popped_burst = ready_keys.pop_front();
    end
    r.occupancy = OCC_W'(ready_keys.size());
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none inside the quiet windows.
  function automatic int unsigned draw_pause();
    int unsigned roll;
    roll = $urandom_range(99);
    if (cycle_count[11:10] == 2'b11 || roll < 65) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [KEY_W-1:0] draw_burst();
    int unsigned roll;
    roll = $urandom_range(99);
    // Narrow range forces many equal bursts, so ordering ties get exercised.
    if (roll < 40) return KEY_W'($urandom_range(7));
    if (roll < 45) return '0;
    if (roll < 50) return '1;
    return KEY_W'($urandom);
  endfunction

  task automatic queue_job(kind_e kind, logic [ID_W-1:0] job_id, logic [KEY_W-1:0] burst);
    job_req_t req;
    req.kind   = kind;
    req.job_id = job_id;
    req.burst  = burst;
    job_requests.push_back(req);
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Request driver: hold a request until taken, predict its result on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= KIND_INSERT;
      send_pause    = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) due_results.push_back(predict_sjf_result(on_bus));
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_pause > 0) begin
          send_pause--;
          s_axis_tvalid <= 1'b0;
        end else if (job_requests.size() > 0) begin
          on_bus = job_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_bus.burst, on_bus.job_id};
          s_axis_tuser  <= on_bus.kind;
          send_pause    = draw_pause();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.popped_valid    = m_axis_tuser[0];
        got.insert_rejected = m_axis_tuser[1];
        got.popped_id       = m_axis_tdata[ID_W-1:0];
        got.popped_burst    = m_axis_tdata[ID_W +: KEY_W];
        got.occupancy       = m_axis_tdata[ID_W+KEY_W +: OCC_W];
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("popped_valid", want.popped_valid, got.popped_valid);
          check_field("popped_id", want.popped_id, got.popped_id);
          check_field("popped_burst", want.popped_burst, got.popped_burst);
          check_field("insert_rejected", want.insert_rejected, got.insert_rejected);
          check_field("occupancy", want.occupancy, got.occupancy);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall    = draw_pause();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, due_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned made;
    int unsigned phase_len;
    int unsigned insert_pct;
    logic [KEY_W-1:0] burst;

    // Directed: pop on empty, fill to the brim with extremes and ties,
    // insert into a full queue, then take a few from the head.
    queue_job(KIND_POP, '1, '1);
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      case (i % 4)
        0: burst = '1;
        1: burst = '0;
        2: burst = KEY_W'(5);
        default: burst = KEY_W'(i);
      endcase
      queue_job(KIND_INSERT, (i == 0) ? '0 : (i == 1) ? '1 : ID_W'(i * 16'h1111), burst);
    end
    queue_job(KIND_INSERT, 16'hBEEF, '0);
    for (int unsigned i = 0; i < 6; i++) queue_job(KIND_POP, ID_W'($urandom), KEY_W'($urandom));

    // Random: phases leaning toward inserts or pops swing the queue between
    // empty and full.
    made = 0;
    while (made < RANDOM_JOBS) begin
      phase_len = $urandom_range(60, 10);
      case ($urandom_range(2))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      for (int unsigned i = 0; i < phase_len && made < RANDOM_JOBS; i++) begin
        queue_job(($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_POP,
                  ID_W'($urandom), draw_burst());
        made++;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (job_requests.size() == 0 && !s_axis_tvalid && due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
